@@ hdl/hbsd_pkg.sv @@
`timescale 1ns / 1ps

package hbsd_pkg;

    localparam int IDX_W  = 6;
    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;
    localparam int CODE_W = 32;
    localparam int CNT_W  = 7;

    // operation codes carried in s_tuser
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    // one code table entry as stored in the table RAM
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
        logic [SYM_W-1:0]  symbol;
    } hbsd_entry_t;

    localparam int ENTRY_W = $bits(hbsd_entry_t);

endpackage

@@ hdl/hbsd_ram.sv @@
`timescale 1ns / 1ps

module hbsd_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/huffman_bit_serial_decoder_top.sv @@
`timescale 1ns / 1ps
// Bit-serial Huffman decoder with a loadable code table.
// Input beats arrive on s_*: s_tuser selects load (write one table entry at
// entry_index) or decode (append code_bit to the pending code). Every input
// beat produces exactly one result beat on m_*.
// cfg_we/cfg_wdata set symbol_count, the number of table entries searched;
// write it only while the block is idle.
// A load beat gives its result in the cycle after acceptance. A decode
// beat walks the table one entry per cycle through the RAM read port, over
// the first min(symbol_count, TABLE_ENTRIES) entries, and ends early on the
// first matching entry. The block takes one beat at a time; s_tready is
// low while a decode scan runs.
// The result sits in an output register; a new beat is taken in the cycle
// the previous result leaves, or once it has left. When m_tready stays low,
// a finished scan holds its result internally and s_tready stays low.
// Reset clears the pending code, symbol_count and all handshake state. The
// table RAM is not cleared: load every entry below symbol_count before
// decoding.
module huffman_bit_serial_decoder_top
    import hbsd_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // [5:0] entry_index, [13:6] entry_symbol, [19:14] entry_length,
    // [51:20] entry_code, [52] code_bit, [55:53] zero
    input  logic [55:0]      s_tdata,
    // [0] operation
    input  logic             s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // [0] symbol_valid, [8:1] symbol, [9] overflow, [15:10] pending_length
    output logic [15:0]      m_tdata
);

    localparam int AW  = $clog2(TABLE_ENTRIES);
    localparam int CW  = $clog2(TABLE_ENTRIES + 1);
    localparam int PW  = MAX_CODE_BITS;
    localparam int PCW = $clog2(MAX_CODE_BITS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PW-1:0]     pend_bits_reg;
    logic [PCW-1:0]    pend_cnt_reg;
    logic [CW-1:0]     issue_reg;
    logic              pvld_reg;
    logic              res_valid_reg;
    logic [SYM_W-1:0]  res_sym_reg;
    logic              res_ovf_reg;
    logic              m_tvalid_reg;
    logic              m_sv_reg;
    logic [SYM_W-1:0]  m_sym_reg;
    logic              m_ovf_reg;
    logic [LEN_W-1:0]  m_plen_reg;

    logic [IDX_W-1:0]  in_index;
    logic [SYM_W-1:0]  in_symbol;
    logic [LEN_W-1:0]  in_length;
    logic [CODE_W-1:0] in_code;
    logic              in_bit;

    logic              s_accept;
    logic              out_free;
    logic              m_load;
    logic [CW-1:0]     n_eff;
    logic              ram_we;
    hbsd_entry_t       wr_entry;
    logic [ENTRY_W-1:0] ram_rdata;
    hbsd_entry_t       rd_entry;
    logic [63:0]       len_mask;
    logic              hit;
    logic              scan_end;

    assign in_index  = s_tdata[5:0];
    assign in_symbol = s_tdata[13:6];
    assign in_length = s_tdata[19:14];
    assign in_code   = s_tdata[51:20];
    assign in_bit    = s_tdata[52];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;

    // a new result beat enters the output register this cycle
    assign m_load = (s_accept && (s_tuser == OP_LOAD)) || ((state_reg == ST_DONE) && out_free);

    // clamp the search count to the table size
    assign n_eff = (32'(count_reg) > TABLE_ENTRIES) ? CW'(TABLE_ENTRIES) : CW'(count_reg);

    assign ram_we = s_accept && (s_tuser == OP_LOAD) && (32'(in_index) < TABLE_ENTRIES);
    assign wr_entry.code   = in_code;
    assign wr_entry.length = in_length;
    assign wr_entry.symbol = in_symbol;

    hbsd_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(AW'(32'(in_index))),
        .wdata(ENTRY_W'(wr_entry)),
        .raddr(issue_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    assign rd_entry = hbsd_entry_t'(ram_rdata);

    // compare the entry read last cycle against the pending code
    always_comb begin
        len_mask = (64'd1 << rd_entry.length) - 64'd1;
        hit = pvld_reg
            && (rd_entry.length != '0)
            && (rd_entry.length == LEN_W'(pend_cnt_reg))
            && ((64'(rd_entry.code) & len_mask) == 64'(pend_bits_reg));
    end

    assign scan_end = !pvld_reg && (issue_reg == n_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            issue_reg     <= '0;
            pvld_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                count_reg <= cfg_wdata;
            end
            if (m_tvalid_reg && m_tready && !m_load) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (s_tuser == OP_LOAD) begin
                            m_tvalid_reg <= 1'b1;
                            m_sv_reg     <= 1'b0;
                            m_sym_reg    <= '0;
                            m_ovf_reg    <= 1'b0;
                            m_plen_reg   <= LEN_W'(pend_cnt_reg);
                        end else begin
                            pend_bits_reg <= PW'({pend_bits_reg, in_bit});
                            pend_cnt_reg  <= pend_cnt_reg + 1'b1;
                            issue_reg     <= '0;
                            pvld_reg      <= 1'b0;
                            state_reg     <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (hit) begin
                        res_valid_reg <= 1'b1;
                        res_sym_reg   <= rd_entry.symbol;
                        res_ovf_reg   <= 1'b0;
                        pend_bits_reg <= '0;
                        pend_cnt_reg  <= '0;
                        state_reg     <= ST_DONE;
                    end else if (scan_end) begin
                        res_valid_reg <= 1'b0;
                        res_sym_reg   <= '0;
                        res_ovf_reg   <= (pend_cnt_reg >= PCW'(MAX_CODE_BITS));
                        // drop the pending code once it reaches the length limit
                        if (pend_cnt_reg >= PCW'(MAX_CODE_BITS)) begin
                            pend_bits_reg <= '0;
                            pend_cnt_reg  <= '0;
                        end
                        state_reg <= ST_DONE;
                    end else begin
                        // advance the read address, one entry per cycle
                        pvld_reg <= (issue_reg != n_eff);
                        if (issue_reg != n_eff) begin
                            issue_reg <= issue_reg + 1'b1;
                        end
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_sv_reg     <= res_valid_reg;
                        m_sym_reg    <= res_sym_reg;
                        m_ovf_reg    <= res_ovf_reg;
                        m_plen_reg   <= LEN_W'(pend_cnt_reg);
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_plen_reg, m_ovf_reg, m_sym_reg, m_sv_reg};

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[9]))
        else $error("symbol and overflow reported together");

    a_clear_on_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[0] || m_tdata[9])) |-> (m_tdata[15:10] == '0))
        else $error("pending code not cleared after symbol or overflow");

    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_cnt_reg <= PCW'(MAX_CODE_BITS))
        else $error("pending count beyond limit");

    a_load_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (s_tuser == OP_LOAD)) |=> (m_tvalid && !m_tdata[0] && !m_tdata[9]))
        else $error("load beat did not give a plain result");

endmodule
